// ===== sv/batch_norm_forward_core_macros.svh =====
// assertion macros for the batch norm forward core checker
// used by bnf_checker only
`ifndef BATCH_NORM_FORWARD_CORE_MACROS_SVH
`define BATCH_NORM_FORWARD_CORE_MACROS_SVH

// implication checked in the same cycle, reset masked
`define BNF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle, reset masked
`define BNF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication checked in the next cycle, also during reset
`define BNF_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bnf_pkg.sv =====
// shared types, constants and commands of the batch norm forward core
// no dependencies
`default_nettype none
package bnf_pkg;
  localparam int DEF_MAX_FEATURES = 64;
  localparam int DEF_MAX_BATCH    = 64;

  localparam int CMD_W   = 2;
  localparam int FEAT_W  = 6;
  localparam int SAMP_W  = 6;
  localparam int VAL_W   = 16;
  localparam int VAR_W   = 32;
  localparam int CFG_W   = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int DIV_W   = 48;
  localparam int SQ_W    = 64;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FETCH = 2'd2;

  localparam logic REG_BATCH   = 1'b0;
  localparam logic REG_FEATURE = 1'b1;
endpackage
`default_nettype wire

// ===== sv/bnf_if.sv =====
// item channel interfaces of the batch norm forward core
// depends on bnf_pkg
`default_nettype none
interface bnf_in_if import bnf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [FEAT_W-1:0]        feature;
  logic [SAMP_W-1:0]        sample;
  logic signed [VAL_W-1:0]  value;
  logic signed [VAL_W-1:0]  scale;
  logic signed [VAL_W-1:0]  shift;
  logic                     last;
  modport source (output valid, command, feature, sample, value, scale, shift, last,
                  input ready);
  modport sink (input valid, command, feature, sample, value, scale, shift, last,
                output ready);
endinterface

interface bnf_out_if import bnf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  normalized;
  logic signed [VAL_W-1:0]  feature_mean;
  logic [VAR_W-1:0]         feature_variance;
  logic                     ready_res;
  modport source (output valid, normalized, feature_mean, feature_variance, ready_res,
                  input ready);
  modport sink (input valid, normalized, feature_mean, feature_variance, ready_res,
                output ready);
endinterface
`default_nettype wire

// ===== sv/bnf_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module bnf_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/bnf_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// no dependencies
`default_nettype none
module bnf_div #(
  parameter int N = 48,
  parameter int D = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [D-1:0] divisor,
  output logic              done,
  output logic [N-1:0]      quotient
);
  localparam int CW = $clog2(N + 1);

  logic [N-1:0] dvd_r;
  logic [D-1:0] rem_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic busy_r, done_r;
  logic [D:0] rem_sh, diff;
  logic ge;

  always_comb begin
    rem_sh = {rem_r, dvd_r[N-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    ge     = rem_sh >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N);
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[D-1:0] : rem_sh[D-1:0];
        dvd_r <= {dvd_r[N-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;
endmodule
`default_nettype wire

// ===== sv/bnf_sqrt.sv =====
// iterative integer square root, one result bit per cycle
// no dependencies
`default_nettype none
module bnf_sqrt #(
  parameter int IN_W = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [IN_W-1:0] radicand,
  output logic                 done,
  output logic [IN_W/2-1:0]    root
);
  localparam int CW = $clog2(IN_W / 2 + 1);

  logic [IN_W-1:0] n_r, res_r, bit_r, t;
  logic [CW-1:0] cnt_r;
  logic busy_r, done_r;

  assign t = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(IN_W / 2);
        n_r    <= radicand;
        res_r  <= '0;
        bit_r  <= {2'b01, {(IN_W - 2){1'b0}}};
      end else if (busy_r) begin
        if (n_r >= t) begin
          n_r   <= n_r - t;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[IN_W/2-1:0];
endmodule
`default_nettype wire

// ===== sv/batch_norm_forward_core.sv =====
// batch norm forward core: stores, statistics sequencer and fetch datapath
// depends on bnf_pkg, bnf_if, bnf_ram, bnf_div, bnf_sqrt
// load and store items are taken in idle; a fetch before statistics returns a registered zero result
// a fetch with statistics runs the square root and then the divider
// a store marked last runs the statistics: per feature a sum pass over the samples,
// a mean division, a squared deviation pass and a variance division, one item at a time
// reset is synchronous active low, clears control state and sets both counts to 1
`default_nettype none
module batch_norm_forward_core import bnf_pkg::*; #(
  parameter int MAX_FEATURES = DEF_MAX_FEATURES,
  parameter int MAX_BATCH    = DEF_MAX_BATCH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  bnf_in_if.sink                  in_ch,
  bnf_out_if.source               out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);
  localparam int SDEPTH = MAX_FEATURES * MAX_BATCH;
  localparam int SA_W   = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int FA_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int BA_W   = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int SUM_W  = VAL_W + 1 + $clog2(MAX_BATCH + 1);
  localparam int VSUM_W = 2 * VAL_W + 2 + $clog2(MAX_BATCH + 1);
  localparam int Y_W    = DIV_W + 2;

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_P1_RD   = 14'b00000000000010,
    ST_P1_ACC  = 14'b00000000000100,
    ST_MEAN_GO = 14'b00000000001000,
    ST_MEAN_WT = 14'b00000000010000,
    ST_P2_RD   = 14'b00000000100000,
    ST_P2_SQ   = 14'b00000001000000,
    ST_P2_ACC  = 14'b00000010000000,
    ST_VAR_GO  = 14'b00000100000000,
    ST_VAR_WT  = 14'b00001000000000,
    ST_F_CAP   = 14'b00010000000000,
    ST_F_MUL   = 14'b00100000000000,
    ST_F_SQ_WT = 14'b01000000000000,
    ST_F_DV_WT = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] bc_r, fc_r, nb, nf;
  logic stats_ready_r;
  logic [FA_W-1:0] f_r;
  logic [BA_W-1:0] s_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [VSUM_W-1:0] vsum_r;
  logic signed [VAL_W-1:0] mean_r;
  logic [2*VAL_W+1:0] sq_r;
  logic s_last, f_last;

  logic fok_r, sok_r;
  logic signed [VAL_W-1:0] fx_r, fm_r, fsc_r, fsh_r;
  logic [VAR_W-1:0] fv_r;
  logic [2*VAL_W:0] prod_r;
  logic neg_r;

  logic out_vld_r, out_rdy_res_r;
  logic signed [VAL_W-1:0] out_norm_r, out_mean_r;
  logic [VAR_W-1:0] out_var_r;

  logic acc, fok, sok;
  logic [SA_W-1:0] in_saddr, st_saddr, s_raddr;
  logic s_we, p_we, m_we;
  logic [VAL_W-1:0] s_rdata;
  logic [2*VAL_W-1:0] p_rdata;
  logic [VAL_W+VAR_W-1:0] m_rdata;

  logic div_start, div_done, sq_start, sq_done;
  logic [DIV_W-1:0] div_dvd, div_q;
  logic [VAR_W-1:0] div_dvs;
  logic [SQ_W/2-1:0] root;

  logic signed [VAL_W:0] d_f, d_s;
  logic [VAL_W:0] ad_f, ad_s;
  logic [VAL_W-1:0] asc;
  logic [SUM_W-1:0] asum;
  logic signed [Y_W-1:0] y_raw;
  logic signed [VAL_W-1:0] y_sat;
  logic [VAR_W-1:0] var_sat;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FEATURE) ? PDATA_W'(fc_r) : PDATA_W'(bc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r <= CFG_W'(1);
      fc_r <= CFG_W'(1);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_FEATURE) begin
        fc_r <= pwdata[CFG_W-1:0];
      end else begin
        bc_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    nb = bc_r;
    if (bc_r == '0) begin
      nb = CFG_W'(1);
    end else if (32'(bc_r) > MAX_BATCH) begin
      nb = CFG_W'(MAX_BATCH);
    end
    nf = fc_r;
    if (fc_r == '0) begin
      nf = CFG_W'(1);
    end else if (32'(fc_r) > MAX_FEATURES) begin
      nf = CFG_W'(MAX_FEATURES);
    end
  end

  // input decode
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_vld_r || out_ch.ready);
  assign acc = in_ch.valid && in_ch.ready;
  assign fok = 32'(in_ch.feature) < MAX_FEATURES;
  assign sok = 32'(in_ch.sample) < MAX_BATCH;
  assign in_saddr = SA_W'(int'(in_ch.sample) * MAX_FEATURES + int'(in_ch.feature));
  assign st_saddr = SA_W'(int'(s_r) * MAX_FEATURES + int'(f_r));
  assign s_raddr  = (state_r == ST_IDLE) ? in_saddr : st_saddr;
  assign s_we = acc && (in_ch.command == CMD_STORE) && fok && sok;
  assign p_we = acc && (in_ch.command == CMD_LOAD) && fok;
  assign m_we = (state_r == ST_VAR_WT) && div_done;
  assign s_last = 32'(s_r) == 32'(nb) - 1;
  assign f_last = 32'(f_r) == 32'(nf) - 1;

  bnf_ram #(.W(VAL_W), .DEPTH(SDEPTH)) u_sample_ram (
    .clk(clk), .we(s_we), .waddr(in_saddr), .wdata(in_ch.value),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  bnf_ram #(.W(2 * VAL_W), .DEPTH(MAX_FEATURES)) u_affine_ram (
    .clk(clk), .we(p_we), .waddr(FA_W'(in_ch.feature)),
    .wdata({in_ch.scale, in_ch.shift}),
    .raddr(FA_W'(in_ch.feature)), .rdata(p_rdata)
  );

  bnf_ram #(.W(VAL_W + VAR_W), .DEPTH(MAX_FEATURES)) u_stat_ram (
    .clk(clk), .we(m_we), .waddr(f_r), .wdata({mean_r, var_sat}),
    .raddr(FA_W'(in_ch.feature)), .rdata(m_rdata)
  );

  bnf_div #(.N(DIV_W), .D(VAR_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_q)
  );

  bnf_sqrt #(.IN_W(SQ_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .radicand(SQ_W'({1'b0, fv_r} + 33'd1) << 30), .done(sq_done), .root(root)
  );

  // datapath helpers
  always_comb begin
    asum  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    d_s   = (VAL_W + 1)'($signed(s_rdata)) - (VAL_W + 1)'(mean_r);
    ad_s  = d_s[VAL_W] ? (VAL_W + 1)'(-d_s) : (VAL_W + 1)'(d_s);
    d_f   = (VAL_W + 1)'(fx_r) - (VAL_W + 1)'(fm_r);
    ad_f  = d_f[VAL_W] ? (VAL_W + 1)'(-d_f) : (VAL_W + 1)'(d_f);
    asc   = fsc_r[VAL_W-1] ? VAL_W'(-fsc_r) : VAL_W'(fsc_r);
    var_sat = (div_q > DIV_W'({VAR_W{1'b1}})) ? {VAR_W{1'b1}} : div_q[VAR_W-1:0];
    y_raw = neg_r ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    y_raw = y_raw + Y_W'(fsh_r);
    if (y_raw > Y_W'(32767)) begin
      y_sat = 16'sh7fff;
    end else if (y_raw < -Y_W'(32768)) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y_raw[VAL_W-1:0];
    end
    sq_start  = state_r == ST_F_MUL;
    div_start = (state_r == ST_MEAN_GO) || (state_r == ST_VAR_GO) ||
                ((state_r == ST_F_SQ_WT) && sq_done);
    div_dvs   = (state_r == ST_F_SQ_WT) ? root : VAR_W'(nb);
    if (state_r == ST_MEAN_GO) begin
      div_dvd = DIV_W'(asum) + DIV_W'(nb >> 1);
    end else if (state_r == ST_VAR_GO) begin
      div_dvd = DIV_W'(vsum_r) + DIV_W'(nb >> 1);
    end else begin
      div_dvd = (DIV_W'(prod_r) << 15) + DIV_W'(root >> 1);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && (in_ch.command == CMD_STORE) && in_ch.last) begin
          state_nxt = ST_P1_RD;
        end else if (acc && (in_ch.command == CMD_FETCH) && stats_ready_r) begin
          state_nxt = ST_F_CAP;
        end
      end
      ST_P1_RD:   state_nxt = ST_P1_ACC;
      ST_P1_ACC:  state_nxt = s_last ? ST_MEAN_GO : ST_P1_RD;
      ST_MEAN_GO: state_nxt = ST_MEAN_WT;
      ST_MEAN_WT: state_nxt = div_done ? ST_P2_RD : ST_MEAN_WT;
      ST_P2_RD:   state_nxt = ST_P2_SQ;
      ST_P2_SQ:   state_nxt = ST_P2_ACC;
      ST_P2_ACC:  state_nxt = s_last ? ST_VAR_GO : ST_P2_RD;
      ST_VAR_GO:  state_nxt = ST_VAR_WT;
      ST_VAR_WT: begin
        if (div_done) begin
          state_nxt = f_last ? ST_IDLE : ST_P1_RD;
        end
      end
      ST_F_CAP:   state_nxt = ST_F_MUL;
      ST_F_MUL:   state_nxt = ST_F_SQ_WT;
      ST_F_SQ_WT: state_nxt = sq_done ? ST_F_DV_WT : ST_F_SQ_WT;
      ST_F_DV_WT: state_nxt = div_done ? ST_IDLE : ST_F_DV_WT;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      stats_ready_r <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_VAR_WT) && div_done && f_last) begin
        stats_ready_r <= 1'b1;
      end else if (acc && (in_ch.command == CMD_STORE)) begin
        stats_ready_r <= 1'b0;
      end
      if ((acc && (in_ch.command == CMD_FETCH) && !stats_ready_r) ||
          ((state_r == ST_F_DV_WT) && div_done)) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && acc) begin
      f_r    <= '0;
      s_r    <= '0;
      sum_r  <= '0;
      fok_r  <= fok;
      sok_r  <= sok;
      out_norm_r    <= '0;
      out_mean_r    <= '0;
      out_var_r     <= '0;
      out_rdy_res_r <= 1'b0;
    end
    case (state_r)
      ST_P1_ACC: begin
        sum_r <= sum_r + SUM_W'($signed(s_rdata));
        s_r   <= s_last ? '0 : s_r + 1'b1;
      end
      ST_MEAN_WT: begin
        if (div_done) begin
          mean_r <= sum_r[SUM_W-1] ? -$signed(div_q[VAL_W-1:0])
                                   : $signed(div_q[VAL_W-1:0]);
          vsum_r <= '0;
        end
      end
      ST_P2_SQ: sq_r <= (2 * VAL_W + 2)'(ad_s * ad_s);
      ST_P2_ACC: begin
        vsum_r <= vsum_r + VSUM_W'(sq_r);
        s_r    <= s_last ? '0 : s_r + 1'b1;
      end
      ST_VAR_WT: begin
        if (div_done) begin
          f_r   <= f_last ? '0 : f_r + 1'b1;
          sum_r <= '0;
        end
      end
      ST_F_CAP: begin
        fx_r  <= (fok_r && sok_r) ? $signed(s_rdata) : '0;
        fm_r  <= fok_r ? $signed(m_rdata[VAL_W+VAR_W-1:VAR_W]) : '0;
        fv_r  <= fok_r ? m_rdata[VAR_W-1:0] : '0;
        fsc_r <= fok_r ? $signed(p_rdata[2*VAL_W-1:VAL_W]) : '0;
        fsh_r <= fok_r ? $signed(p_rdata[VAL_W-1:0]) : '0;
      end
      ST_F_MUL: begin
        prod_r <= (2 * VAL_W + 1)'(ad_f * asc);
        neg_r  <= (d_f[VAL_W] != fsc_r[VAL_W-1]) && (ad_f != '0) && (asc != '0);
      end
      ST_F_DV_WT: begin
        if (div_done) begin
          out_norm_r    <= y_sat;
          out_mean_r    <= fm_r;
          out_var_r     <= fv_r;
          out_rdy_res_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.normalized       = out_norm_r;
  assign out_ch.feature_mean     = out_mean_r;
  assign out_ch.feature_variance = out_var_r;
  assign out_ch.ready_res        = out_rdy_res_r;
endmodule
`default_nettype wire

// ===== sv/bnf_checker.sv =====
// port level checks for the batch norm forward core, bound to the top level
// depends on bnf_pkg and batch_norm_forward_core_macros.svh
`default_nettype none
`include "batch_norm_forward_core_macros.svh"
module bnf_checker import bnf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [VAL_W-1:0]  normalized,
  input wire logic [VAL_W-1:0]  feature_mean,
  input wire logic [VAR_W-1:0]  feature_variance,
  input wire logic              ready_res
);
  `BNF_ASSERT_RST(a_reset_out, !rst_n, !out_valid, "result valid right after reset")
  `BNF_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(normalized),
                   "stalled item changed")
  `BNF_ASSERT_NOW(a_not_ready_zero, out_valid && !ready_res,
                  normalized == '0 && feature_mean == '0 && feature_variance == '0,
                  "item without statistics is not zero")
  `BNF_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready,
                  "input taken while result stalled")
endmodule

bind batch_norm_forward_core bnf_checker u_bnf_checker (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .normalized(out_ch.normalized), .feature_mean(out_ch.feature_mean),
  .feature_variance(out_ch.feature_variance), .ready_res(out_ch.ready_res)
);
`default_nettype wire
